FILE: sv/zwg_pkg.sv
// Shared types and constants of the Zipfian workload generator.
package zwg_pkg;

  localparam int unsigned ENTRY_W   = 33;
  localparam int unsigned DRAW_W    = 32;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned BURST_W   = 16;
  localparam int unsigned KEY_W     = 17;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 33;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_TRIGGER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_THRESH  = 2'd3;

  localparam logic [COUNT_W-1:0] KEY_COUNT_RST    = 13'd4096;
  localparam logic [BURST_W-1:0] BURST_LENGTH_RST = 16'd500;

endpackage

FILE: sv/zipf_workload_generator_core.sv
// Zipfian key-value traffic generator with descending scan bursts.
// A load transfer writes one table entry. A generate transfer gives one operation: a
// scan key inside a running burst passes through S_SCAN and S_EMIT, a transfer that starts
// a burst passes through S_MUL, S_BASE, S_SCAN and S_EMIT, and a Zipfian key passes through
// S_SRCH_ISSUE, a binary search over the clamped key count in S_SRCH_CMP with one read of
// the table memory per search step, and S_EMIT. A finished result waits in the output
// register while the next transfer is accepted. The table has no reset; only loaded entries
// may be searched.
module zipf_workload_generator_core
  import zwg_pkg::*;
#(
  parameter int unsigned MAX_KEYS = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 op_i,
  input  logic [IDX_W-1:0]     entry_index_i,
  input  logic [ENTRY_W-1:0]   entry_value_i,
  input  logic [DRAW_W-1:0]    draw_trigger_i,
  input  logic [DRAW_W-1:0]    draw_offset_i,
  input  logic [DRAW_W-1:0]    draw_key_i,
  input  logic [DRAW_W-1:0]    draw_write_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_put_o,
  output logic                 from_scan_o,
  output logic [KEY_W-1:0]     key_index_o,
  output logic [SEQ_W-1:0]     sequence_res_o
);

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam int unsigned NW = CW + 4;
  localparam int unsigned PW = DRAW_W + NW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_BASE,
    S_SCAN,
    S_SRCH_ISSUE,
    S_SRCH_CMP,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [COUNT_W-1:0]   key_count_q;
  logic [ENTRY_W-1:0]   scan_thresh_q;
  logic [BURST_W-1:0]   burst_length_q;
  logic [ENTRY_W-1:0]   write_thresh_q;

  logic [BURST_W-1:0]   burst_left_q;
  logic [NW-1:0]        burst_base_q;
  logic [SEQ_W-1:0]     op_counter_q;

  logic [CW-1:0]        n_q;
  logic [DRAW_W-1:0]    draw_offset_q;
  logic [DRAW_W-1:0]    draw_key_q;
  logic                 put_q;
  logic [PW-1:0]        prod_q;
  logic [CW-1:0]        lo_q;
  logic [CW-1:0]        span_q;

  logic                 res_put_q;
  logic                 res_scan_q;
  logic [KEY_W-1:0]     res_key_q;

  logic                 out_valid_q;
  logic                 is_put_q;
  logic                 from_scan_q;
  logic [KEY_W-1:0]     key_index_q;
  logic [SEQ_W-1:0]     sequence_q;

  logic [CW-1:0]        live_n;
  logic [NW-1:0]        n10;
  logic [CW-1:0]        half;
  logic [CW-1:0]        probe;
  logic                 go_right;
  logic [CW-1:0]        lo_d;
  logic [CW-1:0]        span_d;
  logic [CW-1:0]        found;
  logic [BURST_W-1:0]   left_dec;
  logic [31:0]          scan_sum;
  logic                 in_xfer;
  logic                 out_free;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic [31:0]          idx_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (key_count_q == '0) begin
      live_n = CW'(1);
    end else if (32'(key_count_q) > MAX_KEYS) begin
      live_n = CW'(MAX_KEYS);
    end else begin
      live_n = CW'(key_count_q);
    end
  end

  assign n10 = (NW'(n_q) << 3) + (NW'(n_q) << 1);

  assign half     = span_q >> 1;
  assign probe    = lo_q + half;
  assign go_right = (ram_rdata < {1'b0, draw_key_q});
  assign lo_d     = go_right ? probe + CW'(1) : lo_q;
  assign span_d   = go_right ? span_q - half - CW'(1) : half;
  assign found    = (lo_d >= n_q) ? n_q - CW'(1) : lo_d;

  assign left_dec = burst_left_q - BURST_W'(1);
  assign scan_sum = 32'(burst_base_q) + 32'(left_dec);

  assign idx_ext   = 32'(entry_index_i);
  assign ram_we    = in_xfer && (op_i == OP_LOAD) && (idx_ext < MAX_KEYS);
  assign ram_waddr = idx_ext[AW-1:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = probe[AW-1:0];
    if (state_q == S_SRCH_ISSUE) begin
      ram_re = 1'b1;
    end else if (state_q == S_SRCH_CMP) begin
      ram_re    = (span_d != '0);
      ram_raddr = AW'(lo_d + (span_d >> 1));
    end
  end

  zwg_cdf_ram #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_cdf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (entry_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q    <= KEY_COUNT_RST;
      scan_thresh_q  <= '0;
      burst_length_q <= BURST_LENGTH_RST;
      write_thresh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KEY_COUNT:    key_count_q    <= cfg_data_i[COUNT_W-1:0];
        REG_SCAN_TRIGGER: scan_thresh_q  <= cfg_data_i[ENTRY_W-1:0];
        REG_BURST_LENGTH: burst_length_q <= cfg_data_i[BURST_W-1:0];
        REG_WRITE_THRESH: write_thresh_q <= cfg_data_i[ENTRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      burst_left_q <= '0;
      burst_base_q <= '0;
      op_counter_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer && (op_i == OP_GENERATE)) begin
            n_q           <= live_n;
            draw_offset_q <= draw_offset_i;
            draw_key_q    <= draw_key_i;
            put_q         <= ({1'b0, draw_write_i} < write_thresh_q);
            op_counter_q  <= op_counter_q + SEQ_W'(1);
            lo_q          <= '0;
            span_q        <= live_n;
            if (burst_left_q == '0 && ({1'b0, draw_trigger_i} < scan_thresh_q)) begin
              state_q <= S_MUL;
            end else if (burst_left_q != '0) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_SRCH_ISSUE;
            end
          end
        end
        S_MUL: begin
          prod_q  <= PW'(draw_offset_q) * PW'(n10);
          state_q <= S_BASE;
        end
        S_BASE: begin
          burst_base_q <= prod_q[PW-1:DRAW_W];
          burst_left_q <= (burst_length_q == '0) ? BURST_W'(1) : burst_length_q;
          op_counter_q <= op_counter_q + SEQ_W'(1);
          state_q      <= S_SCAN;
        end
        S_SCAN: begin
          burst_left_q <= left_dec;
          res_put_q    <= 1'b0;
          res_scan_q   <= 1'b1;
          res_key_q    <= scan_sum[KEY_W-1:0];
          state_q      <= S_EMIT;
        end
        S_SRCH_ISSUE: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          lo_q   <= lo_d;
          span_q <= span_d;
          if (span_d == '0) begin
            res_put_q  <= put_q;
            res_scan_q <= 1'b0;
            res_key_q  <= KEY_W'(found);
            state_q    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            is_put_q    <= res_put_q;
            from_scan_q <= res_scan_q;
            key_index_q <= res_key_q;
            sequence_q  <= op_counter_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_put_o       = is_put_q;
  assign from_scan_o    = from_scan_q;
  assign key_index_o    = key_index_q;
  assign sequence_res_o = sequence_q;

`ifndef SYNTHESIS
  // The search span never grows beyond the clamped key count.
  a_span_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_CMP) |-> (span_q <= n_q))
    else $error("search span exceeds key count");

  // A scan step only happens while a burst is running.
  a_scan_has_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (burst_left_q != '0))
    else $error("scan step with empty burst");

  // Scan keys are always reported as GETs.
  a_scan_is_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && from_scan_o) |-> !is_put_o)
    else $error("scan key reported as PUT");

  // Each accepted generate transfer advances the operation counter by one at once.
  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (op_i == OP_GENERATE))
      |=> (op_counter_q == $past(op_counter_q) + SEQ_W'(1)))
    else $error("operation counter did not advance");
`endif

endmodule

FILE: sv/zwg_cdf_ram.sv
// Single-port-write, single-port-read table of cumulative probabilities.
module zwg_cdf_ram
  import zwg_pkg::*;
#(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
